FILE: rtl/bipartite_check_bfs_macros.svh
// assertion macros for the bipartite check block
`ifndef BIPARTITE_CHECK_BFS_MACROS_SVH
`define BIPARTITE_CHECK_BFS_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define BCB_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define BCB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bcb_pkg.sv
// shared types and constants of the bipartite check block
`default_nettype none
package bcb_pkg;
  localparam logic [1:0] VERDICT_BIPARTITE = 2'd0;
  localparam logic [1:0] VERDICT_ODD_CYCLE = 2'd1;
  localparam logic [1:0] VERDICT_INVALID   = 2'd2;

  localparam logic [1:0] COLOR_NONE = 2'd0;
  localparam logic [1:0] COLOR_ONE  = 2'd1;
  localparam logic [1:0] COLOR_TWO  = 2'd2;

  typedef enum logic [12:0] {
    ST_CLEAR   = 13'b0000000000001,
    ST_IDLE    = 13'b0000000000010,
    ST_LINK_A  = 13'b0000000000100,
    ST_LINK_B  = 13'b0000000001000,
    ST_SCAN    = 13'b0000000010000,
    ST_SCAN_W  = 13'b0000000100000,
    ST_POP     = 13'b0000001000000,
    ST_POP_W   = 13'b0000010000000,
    ST_HEAD_W  = 13'b0000100000000,
    ST_LINK_RD = 13'b0001000000000,
    ST_LINK_W  = 13'b0010000000000,
    ST_COLOR_W = 13'b0100000000000,
    ST_DONE    = 13'b1000000000000
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/bipartite_check_bfs.sv
// top level of the bipartite check block: edge loading and breadth-first two-colouring
// An edge item keeps busy high after its transfer, in ST_LINK_A and ST_LINK_B, one per
// direction, each writing the link memory and head table once; no item is taken
// meanwhile. An empty, non-last item leaves busy low. An item with last_edge set starts
// the search unless an error was seen or vertex_count is zero: ST_SCAN, ST_SCAN_W per
// start candidate; ST_POP, ST_POP_W, ST_HEAD_W per visited vertex and ST_POP after each
// walk; ST_LINK_RD, ST_LINK_W, ST_COLOR_W per link, all set by the single read port of
// each memory. done is then strobed for one cycle with verdict and cannot be held off.
// After each verdict and after reset, busy is high while all MAX_VERTICES head and colour
// entries are cleared. Configuration writes are taken at any time with ready high.
`default_nettype none
`include "bipartite_check_bfs_macros.svh"
module bipartite_check_bfs
  import bcb_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       edge_present,
  input  wire logic [9:0] first_vertex,
  input  wire logic [9:0] second_vertex,
  input  wire logic       last_edge,
  output logic            done,
  output logic [1:0]      verdict,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [9:0] cfg_data
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int SW = $clog2(SLOTS);
  localparam int PW = SW + 1;
  localparam int CW = (VW > 10) ? VW : 10;

  state_t state;
  logic [9:0]  vertex_count;
  logic [PW-1:0] slot_count;
  logic        error_seen;
  logic [VW-1:0] vert_a, vert_b;
  logic        last_hold;
  logic [VW-1:0] scan_v, scan_top, nb_v, q_front, q_back, clr_idx;
  logic [1:0]  cur_c;
  logic [PW-1:0] ptr;
  logic [1:0]  verdict_r;
  logic        done_r;

  logic head_we; logic [VW-1:0] head_wa, head_ra; logic [PW-1:0] head_wd, head_rd;
  logic lnk_we; logic [SW-1:0] lnk_wa, lnk_ra; logic [PW+VW-1:0] lnk_wd, lnk_rd;
  logic col_we; logic [VW-1:0] col_wa, col_ra; logic [1:0] col_wd, col_rd;
  logic q_we; logic [VW-1:0] q_wa, q_ra; logic [VW-1:0] q_wd, q_rd;

  bcb_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_head (.clk(clk), .we(head_we),
    .waddr(head_wa), .wdata(head_wd), .raddr(head_ra), .rdata(head_rd));
  bcb_ram #(.WIDTH(PW+VW), .DEPTH(SLOTS)) u_link (.clk(clk), .we(lnk_we),
    .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));
  bcb_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_color (.clk(clk), .we(col_we),
    .waddr(col_wa), .wdata(col_wd), .raddr(col_ra), .rdata(col_rd));
  bcb_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue (.clk(clk), .we(q_we),
    .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  function automatic logic vert_ok(input logic [9:0] v, input logic [9:0] cnt);
    logic [CW:0] vx;
    vx = (CW+1)'(v);
    return (v != 10'd0) && (v <= cnt) && (vx < (CW+1)'(MAX_VERTICES));
  endfunction

  logic [CW:0] top_full;
  logic [VW-1:0] nb_from_link;
  logic [PW-1:0] next_from_link;
  logic [VW-1:0] link_vert;
  logic [VW-1:0] link_other;
  logic [1:0] opp_c;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign done = done_r;
  assign verdict = verdict_r;
  assign nb_from_link = lnk_rd[VW-1:0];
  assign next_from_link = lnk_rd[PW+VW-1:VW];
  assign link_vert = (state == ST_LINK_A) ? vert_a : vert_b;
  assign link_other = (state == ST_LINK_A) ? vert_b : vert_a;
  assign opp_c = (cur_c == COLOR_ONE) ? COLOR_TWO : COLOR_ONE;
  assign top_full = ((CW+1)'(vertex_count) > (CW+1)'(MAX_VERTICES - 1)) ?
                    (CW+1)'(MAX_VERTICES - 1) : (CW+1)'(vertex_count);

  // head table is read for the old head in the cycle before each link-state write
  always_comb begin
    head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
    lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_ra = ptr[SW-1:0] - SW'(1);
    col_we = 1'b0; col_wa = '0; col_wd = COLOR_NONE; col_ra = scan_v;
    q_we = 1'b0; q_wa = q_back; q_wd = '0; q_ra = q_front;
    unique case (state)
      ST_CLEAR: begin
        head_we = 1'b1; head_wa = clr_idx;
        col_we = 1'b1; col_wa = clr_idx;
      end
      ST_IDLE: begin
        head_ra = VW'(first_vertex);
      end
      ST_LINK_A, ST_LINK_B: begin
        head_ra = vert_b;
        lnk_we = 1'b1; lnk_wa = slot_count[SW-1:0];
        // self-loop: the head written in the first half is forwarded
        lnk_wd = {(state == ST_LINK_B && vert_a == vert_b) ? slot_count : head_rd,
                  link_other};
        head_we = 1'b1; head_wa = link_vert; head_wd = slot_count + PW'(1);
      end
      ST_SCAN: col_ra = scan_v;
      ST_SCAN_W: begin
        col_we = (col_rd == COLOR_NONE); col_wa = scan_v; col_wd = COLOR_ONE;
        q_we = (col_rd == COLOR_NONE); q_wa = '0; q_wd = scan_v;
      end
      ST_POP: q_ra = q_front;
      ST_POP_W: begin
        col_ra = q_rd; head_ra = q_rd;
      end
      ST_HEAD_W: ;
      ST_LINK_RD: ;
      ST_LINK_W: col_ra = nb_from_link;
      ST_COLOR_W: begin
        col_we = (col_rd == COLOR_NONE); col_wa = nb_v; col_wd = opp_c;
        q_we = (col_rd == COLOR_NONE); q_wa = q_back; q_wd = nb_v;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      vertex_count <= 10'd1023;
      clr_idx <= '0;
      slot_count <= '0;
      error_seen <= 1'b0;
      done_r <= 1'b0;
      verdict_r <= VERDICT_BIPARTITE;
      last_hold <= 1'b0;
      q_front <= '0; q_back <= '0;
      scan_v <= '0; scan_top <= '0;
    end else begin
      done_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        vertex_count <= cfg_data;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + VW'(1);
          if (clr_idx == VW'(MAX_VERTICES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            vert_a <= VW'(first_vertex);
            vert_b <= VW'(second_vertex);
            last_hold <= last_edge;
            scan_v <= VW'(1);
            scan_top <= top_full[VW-1:0];
            if (edge_present && (!vert_ok(first_vertex, vertex_count) ||
                !vert_ok(second_vertex, vertex_count) ||
                (slot_count + PW'(2) > PW'(SLOTS)))) begin
              error_seen <= 1'b1;
              state <= last_edge ? ST_DONE : ST_IDLE;
              verdict_r <= VERDICT_INVALID;
            end else if (edge_present) begin
              state <= ST_LINK_A;
            end else if (last_edge) begin
              state <= (error_seen || top_full == '0) ? ST_DONE : ST_SCAN;
              verdict_r <= error_seen ? VERDICT_INVALID : VERDICT_BIPARTITE;
            end
          end
        end
        ST_LINK_A: begin
          slot_count <= slot_count + PW'(1);
          state <= ST_LINK_B;
        end
        ST_LINK_B: begin
          slot_count <= slot_count + PW'(1);
          if (last_hold) begin
            state <= (error_seen || scan_top == '0) ? ST_DONE : ST_SCAN;
            verdict_r <= error_seen ? VERDICT_INVALID : VERDICT_BIPARTITE;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: state <= ST_SCAN_W;
        ST_SCAN_W: begin
          if (col_rd == COLOR_NONE) begin
            q_front <= '0; q_back <= VW'(1);
            state <= ST_POP;
          end else if (scan_v == scan_top) begin
            state <= ST_DONE;
          end else begin
            scan_v <= scan_v + VW'(1);
            state <= ST_SCAN;
          end
        end
        ST_POP: begin
          if (q_front == q_back) begin
            if (scan_v == scan_top) begin
              state <= ST_DONE;
            end else begin
              scan_v <= scan_v + VW'(1);
              state <= ST_SCAN;
            end
          end else begin
            q_front <= q_front + VW'(1);
            state <= ST_POP_W;
          end
        end
        ST_POP_W: state <= ST_HEAD_W;
        ST_HEAD_W: begin
          cur_c <= col_rd;
          ptr <= head_rd;
          state <= (head_rd == '0) ? ST_POP : ST_LINK_RD;
        end
        ST_LINK_RD: state <= ST_LINK_W;
        ST_LINK_W: begin
          nb_v <= nb_from_link;
          ptr <= next_from_link;
          state <= ST_COLOR_W;
        end
        ST_COLOR_W: begin
          if (col_rd == COLOR_NONE) begin
            q_back <= q_back + VW'(1);
          end
          if (col_rd == cur_c) begin
            verdict_r <= VERDICT_ODD_CYCLE;
            state <= ST_DONE;
          end else begin
            state <= (ptr == '0) ? ST_POP : ST_LINK_RD;
          end
        end
        ST_DONE: begin
          done_r <= 1'b1;
          slot_count <= '0;
          error_seen <= 1'b0;
          clr_idx <= '0;
          state <= ST_CLEAR;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  `BCB_ASSERT_IMPL(a_done_idle, clk, rst, done_r, state == ST_CLEAR, "verdict outside clear")
  `BCB_ASSERT_IMPL(a_verdict_range, clk, rst, done_r, verdict_r != 2'd3, "bad verdict code")
  `BCB_ASSERT_IMPL(a_slots, clk, rst, 1'b1, slot_count <= PW'(SLOTS), "link store overrun")
  `BCB_ASSERT_NEXT(a_link_pair, clk, rst, state == ST_LINK_A, state == ST_LINK_B,
                   "edge written in one direction only")
endmodule
`default_nettype wire

FILE: rtl/bcb_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module bcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: tb/bipartite_check_bfs_checker.sv
// checker for the bipartite check block: graph predictor and verdict comparison
module bipartite_check_bfs_checker
  import bcb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       busy,
  input  wire logic       edge_present,
  input  wire logic [9:0] first_vertex,
  input  wire logic [9:0] second_vertex,
  input  wire logic       last_edge,
  input  wire logic       done,
  input  wire logic [1:0] verdict,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [9:0] cfg_data,
  output int              fail_count,
  output int              pending
);
  localparam int NV = 1024;
  localparam int NSLOT = 8192;

  logic [9:0]  vmax;
  logic [13:0] head [NV];
  logic [13:0] nxt [NSLOT];
  logic [9:0]  tgt [NSLOT];
  logic [1:0]  colour [NV];
  logic [9:0]  fifo [NV];
  int          slots;
  bit          bad;
  logic [1:0]  verdicts_due[$];

  function automatic bit vertex_valid(logic [9:0] v);
    return v != 0 && v <= vmax;
  endfunction

  function automatic bit two_colour_from(int s);
    int qf, qb, v, w;
    logic [1:0] c;
    int p;
    qf = 0; qb = 0;
    colour[s] = COLOR_ONE;
    fifo[qb] = 10'(s); qb = (qb + 1) % NV;
    while (qf != qb) begin
      v = fifo[qf]; qf = (qf + 1) % NV;
      c = colour[v];
      p = head[v];
      while (p != 0) begin
        w = tgt[p-1];
        if (colour[w] == COLOR_NONE) begin
          colour[w] = 2'd3 - c;
          fifo[qb] = 10'(w); qb = (qb + 1) % NV;
        end else if (colour[w] == c) begin
          return 0;
        end
        p = nxt[p-1];
      end
    end
    return 1;
  endfunction

  function automatic logic [1:0] graph_verdict();
    if (bad) return VERDICT_INVALID;
    for (int s = 1; s <= vmax; s++)
      if (colour[s] == COLOR_NONE && !two_colour_from(s)) return VERDICT_ODD_CYCLE;
    return VERDICT_BIPARTITE;
  endfunction

  task automatic clear_graph();
    for (int i = 0; i < NV; i++) begin
      head[i] = '0;
      colour[i] = COLOR_NONE;
    end
    slots = 0;
    bad = 0;
  endtask

  task automatic report(string what, logic [1:0] got, logic [1:0] want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  task automatic add_edge(logic [9:0] a, logic [9:0] b);
    tgt[slots] = b; nxt[slots] = head[a]; head[a] = 14'(slots + 1); slots++;
    tgt[slots] = a; nxt[slots] = head[b]; head[b] = 14'(slots + 1); slots++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    vmax = 10'd1023;
    clear_graph();
  end

  always @(posedge clk) begin
    if (rst) begin
      vmax = 10'd1023;
      clear_graph();
    end else begin
      if (done) begin
        if (verdicts_due.size() == 0) report("unexpected verdict", verdict, 2'd0);
        else begin
          logic [1:0] want;
          want = verdicts_due.pop_front();
          if (verdict !== want) report("verdict", verdict, want);
        end
      end
      if (start && !busy) begin
        if (edge_present) begin
          if (!vertex_valid(first_vertex) || !vertex_valid(second_vertex)) bad = 1;
          else if (slots + 2 > NSLOT) bad = 1;
          else add_edge(first_vertex, second_vertex);
        end
        if (last_edge) begin
          verdicts_due = {verdicts_due, graph_verdict()};
          clear_graph();
        end
      end
      if (cfg_valid && cfg_ready) vmax = cfg_data;
    end
    pending = verdicts_due.size();
  end
endmodule

FILE: tb/tb_bipartite_check_bfs.sv
// testbench top for the bipartite check block: stimulus, configuration and verdict
module tb_bipartite_check_bfs;
  import bcb_pkg::*;

  logic clk = 0, rst = 1, start = 0, edge_present = 0, last_edge = 0;
  logic [9:0] first_vertex = 0, second_vertex = 0, cfg_data = 0;
  logic cfg_valid = 0;
  logic busy, done, cfg_ready;
  logic [1:0] verdict;
  int fail_count, pending;
  int cycles = 0;
  int items = 0;
  int burst = 0;
  logic [9:0] vsize = 10'd1023;

  always #5 clk = ~clk;

  bipartite_check_bfs dut (
    .clk, .rst, .start, .busy, .edge_present, .first_vertex, .second_vertex,
    .last_edge, .done, .verdict, .cfg_valid, .cfg_ready, .cfg_data
  );

  bipartite_check_bfs_checker chk (
    .clk, .rst, .start, .busy, .edge_present, .first_vertex, .second_vertex,
    .last_edge, .done, .verdict, .cfg_valid, .cfg_ready, .cfg_data,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("bipartite_check_bfs test failed");
      $finish;
    end
  end

  // one transfer, with burst and gap pacing
  task automatic send(bit p, logic [9:0] a, logic [9:0] b, bit l);
    if (burst == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst = $urandom_range(1, 12);
    end
    burst--;
    start <= 1'b1; edge_present <= p; first_vertex <= a; second_vertex <= b;
    last_edge <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items++;
    if (burst == 0) begin
      start <= 1'b0;
      edge_present <= 1'($urandom_range(0, 1));
      first_vertex <= 10'($urandom); second_vertex <= 10'($urandom);
    end
  endtask

  task automatic wait_idle();
    if (burst != 0) begin
      start <= 1'b0;
      burst = 0;
    end
    while (pending != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
  endtask

  task automatic set_size(logic [9:0] n);
    wait_idle();
    cfg_valid <= 1; cfg_data <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    vsize = n;
  endtask

  function automatic logic [9:0] pick(logic [9:0] n);
    if ($urandom_range(0, 30) == 0) return 10'($urandom);
    return 10'($urandom_range(1, n));
  endfunction

  task automatic random_graph();
    int m;
    bit odd;
    m = $urandom_range(0, 12);
    odd = 1'($urandom_range(0, 1));
    for (int i = 0; i < m; i++) begin
      logic [9:0] a, b;
      a = pick(vsize); b = pick(vsize);
      // bias towards even-odd edges so many graphs are bipartite
      if (!odd && vsize > 1 && a[0] == b[0] && a != 0)
        b = (a == vsize) ? a - 10'd1 : a + 10'd1;
      if ($urandom_range(0, 20) == 0) send(1'b0, 10'($urandom), 10'($urandom), 1'b0);
      else send(1'b1, a, b, 1'b0);
    end
    send(1'($urandom_range(0, 1)), pick(vsize), pick(vsize), 1'b1);
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 0;
    set_size(10'd8);
    send(1'b1, 10'd1, 10'd2, 1'b0); send(1'b1, 10'd2, 10'd3, 1'b0);
    send(1'b1, 10'd3, 10'd4, 1'b0); send(1'b1, 10'd4, 10'd1, 1'b1);
    send(1'b1, 10'd1, 10'd2, 1'b0); send(1'b1, 10'd2, 10'd3, 1'b0);
    send(1'b1, 10'd3, 10'd1, 1'b1);
    send(1'b1, 10'd5, 10'd5, 1'b1);
    send(1'b1, 10'd0, 10'd3, 1'b1);
    send(1'b1, 10'd2, 10'd9, 1'b1);
    send(1'b0, 10'h3ff, 10'h3ff, 1'b1);
    send(1'b1, 10'd8, 10'd7, 1'b0); send(1'b0, 10'd0, 10'd0, 1'b0);
    send(1'b1, 10'd6, 10'd7, 1'b1);
    set_size(10'd1023);
    send(1'b1, 10'd1023, 10'd1, 1'b0); send(1'b1, 10'd1, 10'd1022, 1'b1);
    send(1'b1, 10'd1023, 10'd1023, 1'b1);
    set_size(10'd0);
    send(1'b1, 10'd1, 10'd1, 1'b1);
    set_size(10'd1);
    send(1'b1, 10'd1, 10'd1, 1'b1); send(1'b0, 10'd0, 10'd0, 1'b1);
    set_size(10'd2);
    send(1'b1, 10'd1, 10'd2, 1'b1);
    set_size(10'd16);
    while (items < 950) begin
      if ($urandom_range(0, 60) == 0) begin
        logic [9:0] n;
        case ($urandom_range(0, 3))
          0: n = 10'd1;
          1: n = 10'd1023;
          default: n = 10'($urandom_range(2, 40));
        endcase
        set_size(n);
      end
      random_graph();
    end
    wait_idle();
    if (fail_count == 0) $display("bipartite_check_bfs test passed");
    else $display("bipartite_check_bfs test failed");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/bcb_pkg.sv
rtl/bcb_ram.sv
rtl/bipartite_check_bfs.sv
tb/bipartite_check_bfs_checker.sv
tb/tb_bipartite_check_bfs.sv
